/* hdl/sha1h_pkg.sv */
package sha1h_pkg;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] SCHED_FILL = 7'd16;
	localparam logic [2:0] LAST_WORD  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       push;
		logic [7:0] byte_val;
		logic       word_done;
		logic       rnd;
		logic [6:0] rnd_t;
		logic       fold;
		logic       init;
		logic [2:0] idx;
	} ctl_t;

	function automatic logic [31:0] rnd_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = K0;
		end else if (t < 7'd40) begin
			k = K1;
		end else if (t < 7'd60) begin
			k = K2;
		end else begin
			k = K3;
		end
		return k;
	endfunction

	function automatic logic [31:0] rnd_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t >= 7'd40 && t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

/* hdl/sha1h_ctrl.sv */
module sha1h_ctrl
	import sha1h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic       dig_ready,
	output logic       req_ready,
	output logic       dig_valid,
	output ctl_t       ctl
);

	state_t      state_q, state_nx;
	logic [5:0]  pos_q;
	logic [6:0]  t_q;
	logic [63:0] len_q;
	logic [2:0]  idx_q;
	logic        fin_q, first_q, lenph_q, done_q;
	logic        is_len, wrap;
	logic [7:0]  pad_byte;

	assign is_len   = !first_q && (lenph_q || pos_q == LEN_POS);
	assign pad_byte = first_q ? PAD_BYTE : (is_len ? len_q[63:56] : 8'h00);
	assign wrap     = pos_q == LAST_POS;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_type) begin
						state_nx = ST_PAD;
					end else if (wrap) begin
						state_nx = ST_ROUND;
					end
				end
			end
			ST_PAD: begin
				if (wrap) begin
					state_nx = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (t_q == LAST_ROUND) begin
					state_nx = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (done_q) begin
					state_nx = ST_OUT;
				end else if (fin_q) begin
					state_nx = ST_PAD;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (dig_ready && idx_q == LAST_WORD) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.word_done = pos_q[1:0] == 2'b11;
		ctl.rnd_t     = t_q;
		ctl.idx       = idx_q;
		req_ready     = 1'b0;
		dig_valid     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready    = 1'b1;
				ctl.push     = req_valid && !req_type;
				ctl.byte_val = data_byte;
			end
			ST_PAD: begin
				ctl.push     = 1'b1;
				ctl.byte_val = pad_byte;
			end
			ST_ROUND: ctl.rnd = 1'b1;
			ST_FOLD:  ctl.fold = 1'b1;
			ST_OUT: begin
				dig_valid = 1'b1;
				ctl.init  = dig_ready && idx_q == LAST_WORD;
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			t_q     <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			lenph_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.push) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req_type) begin
						fin_q   <= 1'b1;
						first_q <= 1'b1;
					end else if (req_valid) begin
						len_q <= len_q + 64'd8;
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (is_len) begin
						len_q   <= {len_q[55:0], 8'h00};
						lenph_q <= 1'b1;
						if (wrap) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_ROUND: begin
					t_q <= (t_q == LAST_ROUND) ? 7'd0 : t_q + 7'd1;
				end
				ST_OUT: begin
					if (dig_ready) begin
						if (idx_q == LAST_WORD) begin
							idx_q   <= '0;
							fin_q   <= 1'b0;
							lenph_q <= 1'b0;
							done_q  <= 1'b0;
							len_q   <= '0;
							pos_q   <= '0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* hdl/sha1h_sched.sv */
module sha1h_sched
	import sha1h_pkg::*;
(
	input  logic        clk,
	input  ctl_t        ctl,
	output logic [31:0] w_t
);

	logic [31:0] w_q [16];
	logic [23:0] word_q;
	logic [31:0] mix, in_word;
	logic        shift_en;

	// window holds w[t-16] at the bottom and w[t-1] at the top
	assign mix      = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_t      = (ctl.rnd_t < SCHED_FILL) ? w_q[0] : {mix[30:0], mix[31]};
	assign shift_en = ctl.rnd || (ctl.push && ctl.word_done);
	assign in_word  = ctl.rnd ? w_t : {word_q, ctl.byte_val};

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= in_word;
		end
		if (ctl.push) begin
			word_q <= {word_q[15:0], ctl.byte_val};
		end
	end

endmodule

/* hdl/sha1h_core.sv */
module sha1h_core
	import sha1h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	input  logic [31:0] w_t,
	output logic [31:0] digest
);

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h0_q, h1_q, h2_q, h3_q, h4_q;
	logic [31:0] a_i, b_i, c_i, d_i, e_i, tmp;
	logic        start;

	// first round takes its working variables straight from the chaining words
	assign start = ctl.rnd_t == 7'd0;
	assign a_i   = start ? h0_q : a_q;
	assign b_i   = start ? h1_q : b_q;
	assign c_i   = start ? h2_q : c_q;
	assign d_i   = start ? h3_q : d_q;
	assign e_i   = start ? h4_q : e_q;
	assign tmp   = {a_i[26:0], a_i[31:27]} + rnd_f(ctl.rnd_t, b_i, c_i, d_i) + e_i + w_t
		+ rnd_k(ctl.rnd_t);

	always_ff @(posedge clk) begin
		if (ctl.rnd) begin
			a_q <= tmp;
			b_q <= a_i;
			c_q <= {b_i[1:0], b_i[31:2]};
			d_q <= c_i;
			e_q <= d_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q <= IV0;
			h1_q <= IV1;
			h2_q <= IV2;
			h3_q <= IV3;
			h4_q <= IV4;
		end else if (ctl.init) begin
			h0_q <= IV0;
			h1_q <= IV1;
			h2_q <= IV2;
			h3_q <= IV3;
			h4_q <= IV4;
		end else if (ctl.fold) begin
			h0_q <= h0_q + a_q;
			h1_q <= h1_q + b_q;
			h2_q <= h2_q + c_q;
			h3_q <= h3_q + d_q;
			h4_q <= h4_q + e_q;
		end
	end

	always_comb begin
		case (ctl.idx)
			3'd0:    digest = h0_q;
			3'd1:    digest = h1_q;
			3'd2:    digest = h2_q;
			3'd3:    digest = h3_q;
			default: digest = h4_q;
		endcase
	end

endmodule

/* hdl/sha1_message_hasher.sv */
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_type, data_byte
// dig      out  dig_valid/dig_ready    digest_word, word_index, last_word
//
// a data byte is accepted while idle; the 64th byte of a block then starts the
// rounds on the one shared round adder, followed by a fold
// a finish is accepted, then pad bytes, the rounds and fold per block, then five beats
// req_ready is low while padding, compressing and sending the digest
// arst_n clears the sequencer and loads the initial chaining words
module sha1_message_hasher
	import sha1h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        dig_valid,
	input  logic        dig_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	ctl_t        ctl;
	logic [31:0] w_t;

	sha1h_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.data_byte (data_byte),
		.dig_ready (dig_ready),
		.req_ready (req_ready),
		.dig_valid (dig_valid),
		.ctl       (ctl)
	);

	sha1h_sched u_sched (
		.clk (clk),
		.ctl (ctl),
		.w_t (w_t)
	);

	sha1h_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w_t    (w_t),
		.digest (digest_word)
	);

	assign word_index = ctl.idx;
	assign last_word  = ctl.idx == LAST_WORD;

endmodule

/* hdl/sha1h_checker.sv */
module sha1h_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_type,
	input logic        dig_valid,
	input logic        dig_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// no new request while the digest is going out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && dig_valid))
		else $error("req_ready high during digest output");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last_word does not match word_index");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !last_word |=>
			dig_valid && word_index == $past(word_index) + 3'd1)
		else $error("digest words out of order");

	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_type |=> !dig_valid)
		else $error("digest after a data beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(digest_word))
		else $error("stalled digest beat changed");

endmodule

bind sha1_message_hasher sha1h_checker u_chk (.*);

/* test/tb_sha1_message_hasher.sv */
`timescale 1ns / 100ps

module tb_sha1_message_hasher;
	import sha1h_pkg::*;

	localparam logic REQ_DATA   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	typedef struct {
		logic       kind;
		logic [7:0] val;
		bit         hold;
		bit         calm;
	} req_beat_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic        req_type = REQ_DATA;
	logic [7:0]  data_byte = 8'h00;
	logic        dig_valid;
	logic        dig_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// stimulus and expected digests
	req_beat_t    beat_q[$];
	req_beat_t    cur_beat;
	digest_beat_t digest_q[$];

	// running hash state
	logic [31:0] msg_words[16];
	logic [31:0] chain_h[5];
	logic [5:0]  fill_pos;
	logic [63:0] msg_bits;

	bit gen_calm = 1'b0;
	bit calm_tail = 1'b0;
	bit failed = 1'b0;
	int n_items = 0;
	int n_finish = 0;
	int gap_left = 0;
	int gap_pct = 20;
	int stall_left = 0;
	int stall_pct = 20;

	sha1_message_hasher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.data_byte   (data_byte),
		.dig_valid   (dig_valid),
		.dig_ready   (dig_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always #2 clk = ~clk;

	function automatic void hash_restart();
		chain_h[0] = IV0;
		chain_h[1] = IV1;
		chain_h[2] = IV2;
		chain_h[3] = IV3;
		chain_h[4] = IV4;
		fill_pos = '0;
		msg_bits = '0;
	endfunction

	function automatic void hash_compress();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, sum;
		for (int t = 0; t < 16; t++) begin
			w[t] = msg_words[t];
		end
		for (int t = 16; t < 80; t++) begin
			sum = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
			w[t] = {sum[30:0], sum[31]};
		end
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int t = 0; t < 80; t++) begin
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			sum = {a[26:0], a[31:27]} + f + e + w[t] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	function automatic void hash_absorb(logic [7:0] v);
		int sh;
		sh = 24 - 8 * fill_pos[1:0];
		msg_words[fill_pos[5:2]][sh +: 8] = v;
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0) begin
			hash_compress();
		end
	endfunction

	function automatic void hash_consume(req_beat_t rb);
		if (rb.kind == REQ_DATA) begin
			hash_absorb(rb.val);
			msg_bits = msg_bits + 64'd8;
		end else begin
			hash_absorb(PAD_BYTE);
			while (fill_pos != LEN_POS) begin
				hash_absorb(8'h00);
			end
			for (int i = 0; i < 8; i++) begin
				hash_absorb(msg_bits[63 - 8 * i -: 8]);
			end
			for (int i = 0; i < 5; i++) begin
				digest_q.push_back('{word: chain_h[i], idx: 3'(i), last: (3'(i) == LAST_WORD)});
			end
			hash_restart();
			gap_pct = $urandom_range(0, 3) * 12;
		end
	endfunction

	task automatic queue_beat(logic kind, logic [7:0] v, bit hold);
		beat_q.push_back('{kind: kind, val: v, hold: hold, calm: gen_calm});
		n_items++;
		if (kind == REQ_FINISH) begin
			n_finish++;
		end
	endtask

	task automatic queue_message(int len, bit hold);
		int fill;
		logic [7:0] v;
		fill = $urandom_range(0, 7);
		for (int i = 0; i < len; i++) begin
			v = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			queue_beat(REQ_DATA, v, hold && i == 0);
		end
		queue_beat(REQ_FINISH, 8'($urandom_range(0, 255)), hold && len == 0);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				hash_consume(cur_beat);
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (!calm_tail && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(1, 7) - 1;
					req_valid <= 1'b0;
				end else if (beat_q.size() != 0 && (!beat_q[0].hold || digest_q.size() == 0)) begin
					cur_beat = beat_q.pop_front();
					if (cur_beat.calm) begin
						calm_tail = 1'b1;
					end
					req_valid <= 1'b1;
					req_type <= cur_beat.kind;
					data_byte <= cur_beat.val;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			dig_ready <= 1'b0;
		end else begin
			if (dig_valid && dig_ready) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest beat word %h index %0d last %b",
						$time, digest_word, word_index, last_word);
					failed = 1'b1;
				end else begin
					exp_beat = digest_q.pop_front();
					if (digest_word !== exp_beat.word) begin
						$display("%0t: digest_word expected %h actual %h",
							$time, exp_beat.word, digest_word);
						failed = 1'b1;
					end
					if (word_index !== exp_beat.idx) begin
						$display("%0t: word_index expected %0d actual %0d",
							$time, exp_beat.idx, word_index);
						failed = 1'b1;
					end
					if (last_word !== exp_beat.last) begin
						$display("%0t: last_word expected %b actual %b",
							$time, exp_beat.last, last_word);
						failed = 1'b1;
					end
				end
				if (last_word) begin
					stall_pct = $urandom_range(0, 2) * 20;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				dig_ready <= 1'b0;
			end else if (!calm_tail && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 7) - 1;
				dig_ready <= 1'b0;
			end else begin
				dig_ready <= 1'b1;
			end
		end
	end

	initial begin
		int sel;
		int len;
		bit first;
		hash_restart();

		// directed: empty message, known text, byte extremes, back to back finishes
		queue_beat(REQ_FINISH, 8'h00, 1'b0);
		queue_beat(REQ_DATA, 8'h61, 1'b0);
		queue_beat(REQ_DATA, 8'h62, 1'b0);
		queue_beat(REQ_DATA, 8'h63, 1'b0);
		queue_beat(REQ_FINISH, 8'hFF, 1'b0);
		queue_beat(REQ_DATA, 8'h00, 1'b0);
		queue_beat(REQ_FINISH, 8'h00, 1'b0);
		queue_beat(REQ_DATA, 8'hFF, 1'b0);
		queue_beat(REQ_FINISH, 8'hFF, 1'b0);
		queue_beat(REQ_FINISH, 8'h55, 1'b0);
		queue_beat(REQ_FINISH, 8'hAA, 1'b0);
		queue_beat(REQ_DATA, 8'h80, 1'b0);
		queue_beat(REQ_DATA, 8'h55, 1'b0);
		queue_beat(REQ_DATA, 8'hAA, 1'b0);
		queue_beat(REQ_FINISH, 8'h00, 1'b0);

		// random messages, lengths biased towards the padding boundaries
		first = 1'b1;
		while (n_items < 60 || n_finish < 8) begin
			sel = $urandom_range(0, 7);
			case (sel)
				0, 1: begin
					len = $urandom_range(0, 4);
				end
				2, 3: begin
					len = $urandom_range(5, 40);
				end
				4: begin
					len = $urandom_range(54, 58);
				end
				5: begin
					len = $urandom_range(62, 66);
				end
				6: begin
					len = $urandom_range(118, 121);
				end
				default: begin
					len = $urandom_range(0, 70);
				end
			endcase
			queue_message(len, first || $urandom_range(0, 5) == 0);
			first = 1'b0;
		end

		// quiet tail
		gen_calm = 1'b1;
		queue_message($urandom_range(0, 8), 1'b0);
		queue_message(64, 1'b0);
		queue_message($urandom_range(55, 57), 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (beat_q.size() != 0 || req_valid || digest_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);
		if (!failed && digest_q.size() == 0) begin
			$display("[sha1_message_hasher] OK");
		end else begin
			$display("[sha1_message_hasher] ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[sha1_message_hasher] ERROR");
		$finish;
	end

endmodule
